/* rtl/rti_pkg.sv */
// Shared widths, types and helpers for the ray/triangle intersection core.
`timescale 1ns / 1ps

package rti_pkg;

    // Coordinate format
    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 12;

    // Derived datapath widths
    localparam int BW  = COORD_WIDTH + 1;          // coordinate or vertex difference
    localparam int PW  = BW + COORD_WIDTH;         // cross product term
    localparam int CW  = PW + 1 - FRAC_BITS;       // cross component after shift
    localparam int MW  = BW + CW;                  // dot product term
    localparam int DW  = MW + 2;                   // dot product sum

    // Output formats and divider lengths
    localparam int OUT_FRAC = 16;
    localparam int T_SAT    = 15;                  // |t| >= 2^T_SAT saturates
    localparam int QT       = OUT_FRAC + T_SAT;    // quotient bits of t
    localparam int QU       = OUT_FRAC + 1;        // quotient bits of u and v
    localparam int DIST_W   = 32;
    localparam int BARY_W   = 17;

    // Stream widths
    localparam int N_IN_FIELDS = 9;
    localparam int S_TDATA_W   = ((N_IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DIST_W + 2 * BARY_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = 3;

    // Configuration port
    localparam int ADDR_W     = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        RSN_HIT = 2'd0,
        RSN_DET = 2'd1,
        RSN_U   = 2'd2,
        RSN_V   = 2'd3
    } t_reason;

    // Sideband that travels with an item through the divider
    typedef struct packed {
        t_reason reason;
        logic    sat;
        logic    neg;
    } t_meta;

    typedef logic signed [BW-1:0] t_bvec [3];
    typedef logic signed [CW-1:0] t_cvec [3];

    // One restoring division step: shift in a numerator bit, subtract if it fits.
    // Result: {quotient bit, new remainder}.
    function automatic logic [DW:0] div_step(input logic [DW-1:0] r,
                                             input logic [DW-1:0] d,
                                             input logic          b);
        logic [DW-1:0] s;
        s = {r[DW-2:0], b};
        if (s >= d) begin
            return {1'b1, s - d};
        end else begin
            return {1'b0, s};
        end
    endfunction

endpackage

/* rtl/rti_cross_unit.sv */
// Two-stage cross products dir x e2 and bv x e1.
`timescale 1ns / 1ps

module rti_cross_unit
    import rti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_bvec i_dir,
    input  t_bvec i_e1,
    input  t_bvec i_e2,
    input  t_bvec i_bv,
    output logic  o_valid,
    output t_cvec o_c1,
    output t_cvec o_c2,
    output t_bvec o_e1,
    output t_bvec o_e2,
    output t_bvec o_bv
);

    logic                 r_v2;
    logic signed [PW-1:0] r_p1 [6];
    logic signed [PW-1:0] r_p2 [6];
    t_bvec                r_e12, r_e2b, r_bv2;

    // Stage A: the twelve products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
        end
        if (i_en) begin
            r_p1[0] <= PW'(i_dir[1]) * PW'(i_e2[2]);
            r_p1[1] <= PW'(i_dir[2]) * PW'(i_e2[1]);
            r_p1[2] <= PW'(i_dir[2]) * PW'(i_e2[0]);
            r_p1[3] <= PW'(i_dir[0]) * PW'(i_e2[2]);
            r_p1[4] <= PW'(i_dir[0]) * PW'(i_e2[1]);
            r_p1[5] <= PW'(i_dir[1]) * PW'(i_e2[0]);
            r_p2[0] <= PW'(i_bv[1]) * PW'(i_e1[2]);
            r_p2[1] <= PW'(i_bv[2]) * PW'(i_e1[1]);
            r_p2[2] <= PW'(i_bv[2]) * PW'(i_e1[0]);
            r_p2[3] <= PW'(i_bv[0]) * PW'(i_e1[2]);
            r_p2[4] <= PW'(i_bv[0]) * PW'(i_e1[1]);
            r_p2[5] <= PW'(i_bv[1]) * PW'(i_e1[0]);
            r_e12   <= i_e1;
            r_e2b   <= i_e2;
            r_bv2   <= i_bv;
        end
    end

    // Stage B: differences, floor shift by the fraction bits
    logic signed [PW:0] n_d1 [3];
    logic signed [PW:0] n_d2 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_d1[k] = (PW+1)'(r_p1[2*k]) - (PW+1)'(r_p1[2*k+1]);
            n_d2[k] = (PW+1)'(r_p2[2*k]) - (PW+1)'(r_p2[2*k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v2;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                o_c1[k] <= n_d1[k][PW:FRAC_BITS];
                o_c2[k] <= n_d2[k][PW:FRAC_BITS];
            end
            o_e1 <= r_e12;
            o_e2 <= r_e2b;
            o_bv <= r_bv2;
        end
    end

endmodule

/* rtl/rti_dot_unit.sv */
// Two-stage dot products: det, u, v and t numerators.
`timescale 1ns / 1ps

module rti_dot_unit
    import rti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_bvec                i_dir,
    input  t_bvec                i_e1,
    input  t_bvec                i_e2,
    input  t_bvec                i_bv,
    input  t_cvec                i_c1,
    input  t_cvec                i_c2,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_det,
    output logic signed [DW-1:0] o_nu,
    output logic signed [DW-1:0] o_nv,
    output logic signed [DW-1:0] o_nt
);

    logic                 r_v;
    logic signed [MW-1:0] r_pd [3];
    logic signed [MW-1:0] r_pu [3];
    logic signed [MW-1:0] r_pv [3];
    logic signed [MW-1:0] r_pt [3];

    // Stage A: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= MW'(i_e1[k])  * MW'(i_c1[k]);
                r_pu[k] <= MW'(i_bv[k])  * MW'(i_c1[k]);
                r_pv[k] <= MW'(i_dir[k]) * MW'(i_c2[k]);
                r_pt[k] <= MW'(i_e2[k])  * MW'(i_c2[k]);
            end
        end
    end

    // Stage B: sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v;
        end
        if (i_en) begin
            o_det <= DW'(r_pd[0]) + DW'(r_pd[1]) + DW'(r_pd[2]);
            o_nu  <= DW'(r_pu[0]) + DW'(r_pu[1]) + DW'(r_pu[2]);
            o_nv  <= DW'(r_pv[0]) + DW'(r_pv[1]) + DW'(r_pv[2]);
            o_nt  <= DW'(r_pt[0]) + DW'(r_pt[1]) + DW'(r_pt[2]);
        end
    end

endmodule

/* rtl/rti_divider.sv */
// Pipelined restoring divider: one quotient bit of t per stage, and of u and v in the first QU stages.
`timescale 1ns / 1ps

module rti_divider
    import rti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_meta            i_meta,
    input  logic [DW-1:0]    i_d,
    input  logic [DW-1:0]    i_rt,
    input  logic [T_SAT-1:0] i_tbits,
    input  logic [DW-1:0]    i_ru,
    input  logic             i_ubit,
    input  logic [DW-1:0]    i_rv,
    input  logic             i_vbit,
    output logic             o_valid,
    output t_meta            o_meta,
    output logic [QT-1:0]    o_qt,
    output logic [QU-1:0]    o_qu,
    output logic [QU-1:0]    o_qv
);

    logic             r_valid [QT];
    t_meta            r_meta  [QT];
    logic [DW-1:0]    r_d     [QT];
    logic [DW-1:0]    r_rt    [QT];
    logic [T_SAT-1:0] r_tb    [QT];
    logic [DW-1:0]    r_ru    [QT];
    logic [DW-1:0]    r_rv    [QT];
    logic [QT-1:0]    r_qt    [QT];
    logic [QU-1:0]    r_qu    [QT];
    logic [QU-1:0]    r_qv    [QT];

    for (genvar k = 0; k < QT; k++) begin : g_stage
        logic             p_valid;
        t_meta            p_meta;
        logic [DW-1:0]    p_d, p_rt, p_ru, p_rv;
        logic [T_SAT-1:0] p_tb;
        logic [QT-1:0]    p_qt;
        logic [QU-1:0]    p_qu, p_qv;
        logic             p_ub, p_vb;
        logic [DW:0]      s_t, s_u, s_v;

        // Previous stage, or the divider inputs at the head
        if (k == 0) begin : g_head
            assign p_valid = i_valid;
            assign p_meta  = i_meta;
            assign p_d     = i_d;
            assign p_rt    = i_rt;
            assign p_tb    = i_tbits;
            assign p_ru    = i_ru;
            assign p_rv    = i_rv;
            assign p_qt    = '0;
            assign p_qu    = '0;
            assign p_qv    = '0;
            assign p_ub    = i_ubit;
            assign p_vb    = i_vbit;
        end else begin : g_body
            assign p_valid = r_valid[k-1];
            assign p_meta  = r_meta[k-1];
            assign p_d     = r_d[k-1];
            assign p_rt    = r_rt[k-1];
            assign p_tb    = r_tb[k-1];
            assign p_ru    = r_ru[k-1];
            assign p_rv    = r_rv[k-1];
            assign p_qt    = r_qt[k-1];
            assign p_qu    = r_qu[k-1];
            assign p_qv    = r_qv[k-1];
            assign p_ub    = 1'b0;
            assign p_vb    = 1'b0;
        end

        // Numerator bits of t come from the low magnitude bits, then zeros
        assign s_t = div_step(p_rt, p_d, p_tb[T_SAT-1]);
        assign s_u = div_step(p_ru, p_d, p_ub);
        assign s_v = div_step(p_rv, p_d, p_vb);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= p_valid;
            end
            if (i_en) begin
                r_meta[k] <= p_meta;
                r_d[k]    <= p_d;
                r_rt[k]   <= s_t[DW-1:0];
                r_tb[k]   <= p_tb << 1;
                r_qt[k]   <= {p_qt[QT-2:0], s_t[DW]};
                if (k < QU) begin
                    r_ru[k] <= s_u[DW-1:0];
                    r_rv[k] <= s_v[DW-1:0];
                    r_qu[k] <= {p_qu[QU-2:0], s_u[DW]};
                    r_qv[k] <= {p_qv[QU-2:0], s_v[DW]};
                end else begin
                    r_ru[k] <= p_ru;
                    r_rv[k] <= p_rv;
                    r_qu[k] <= p_qu;
                    r_qv[k] <= p_qv;
                end
            end
        end
    end

    assign o_valid = r_valid[QT-1];
    assign o_meta  = r_meta[QT-1];
    assign o_qt    = r_qt[QT-1];
    assign o_qu    = r_qu[QT-1];
    assign o_qv    = r_qv[QT-1];

endmodule

/* rtl/ray_triangle_intersect_core.sv */
// Top level: ray registers, triangle stream, intersection pipeline.
//
//  channel   | dir | handshake               | payload
//  s_*       | in  | s_tvalid / s_tready     | s_tdata: triangle (vertex, edge a, edge b)
//  m_*       | out | m_tvalid / m_tready     | m_tdata: t, u, v;  m_tuser: hit, reason
//  apb       | in  | psel, penable, pready=1 | paddr, pwdata, prdata: ray and min_det
//
// One item per cycle unless m_* stalls; stages: input, two cross stages,
// two dot stages, test stage, 31 divider stages, output register. The
// divider, one quotient bit per stage for the 31 bits of t, sets the depth.
// Reset is synchronous; it clears the valid bits and the ray origin and sets the direction to (0, 0, 1.0).
// A stall on m_* freezes the whole pipeline; nothing is dropped or repeated.
`timescale 1ns / 1ps

module ray_triangle_intersect_core
    import rti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // triangle stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata, low bit up: vert_x, vert_y, vert_z, edge_a_x, edge_a_y, edge_a_z,
    //                      edge_b_x, edge_b_y, edge_b_z
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata, low bit up: dist_res, bary_u, bary_v, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser, low bit up: hit, miss_reason
    output logic [M_TUSER_W-1:0]  m_tuser,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [2:0] REG_ORG_X = 3'd0;
    localparam logic [2:0] REG_ORG_Y = 3'd1;
    localparam logic [2:0] REG_ORG_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X = 3'd3;
    localparam logic [2:0] REG_DIR_Y = 3'd4;
    localparam logic [2:0] REG_DIR_Z = 3'd5;
    localparam logic [2:0] REG_MIN_D = 3'd6;

    localparam logic [COORD_WIDTH-1:0] DIR_Z_RESET = COORD_WIDTH'(1 << FRAC_BITS);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] r_org [3];
    logic signed [COORD_WIDTH-1:0] r_dir [3];
    logic        [31:0]            r_min_det;
    logic [2:0]                    n_idx;
    logic                          n_wr;

    assign pready = 1'b1;
    assign n_idx  = paddr[ADDR_W-1:2];
    assign n_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_dir[0]  <= '0;
            r_dir[1]  <= '0;
            r_dir[2]  <= DIR_Z_RESET;
            r_min_det <= 32'd1;
        end else if (n_wr) begin
            unique case (n_idx)
                REG_ORG_X: r_org[0]  <= pwdata[COORD_WIDTH-1:0];
                REG_ORG_Y: r_org[1]  <= pwdata[COORD_WIDTH-1:0];
                REG_ORG_Z: r_org[2]  <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_X: r_dir[0]  <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_Y: r_dir[1]  <= pwdata[COORD_WIDTH-1:0];
                REG_DIR_Z: r_dir[2]  <= pwdata[COORD_WIDTH-1:0];
                REG_MIN_D: r_min_det <= pwdata;
                default:   ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (n_idx)
            REG_ORG_X: prdata = APB_DATA_W'($unsigned(r_org[0]));
            REG_ORG_Y: prdata = APB_DATA_W'($unsigned(r_org[1]));
            REG_ORG_Z: prdata = APB_DATA_W'($unsigned(r_org[2]));
            REG_DIR_X: prdata = APB_DATA_W'($unsigned(r_dir[0]));
            REG_DIR_Y: prdata = APB_DATA_W'($unsigned(r_dir[1]));
            REG_DIR_Z: prdata = APB_DATA_W'($unsigned(r_dir[2]));
            REG_MIN_D: prdata = r_min_det;
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Pipeline advance: the whole pipe moves unless the output is held
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic n_en;

    assign n_en     = !r_out_valid || m_tready;
    assign s_tready = n_en;

    // Ray direction widened for the datapath
    t_bvec n_dir;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_dir[k] = BW'(r_dir[k]);
        end
    end

    // ---------------------------------------------------------------
    // Input stage: unpack and form bv = origin - vertex
    // ---------------------------------------------------------------
    logic  r1_valid;
    t_bvec r1_e1, r1_e2, r1_bv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (n_en) begin
            r1_valid <= s_tvalid;
        end
        if (n_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_bv[k] <= BW'(r_org[k])
                          - BW'($signed(s_tdata[k*COORD_WIDTH +: COORD_WIDTH]));
                r1_e1[k] <= BW'($signed(s_tdata[(3+k)*COORD_WIDTH +: COORD_WIDTH]));
                r1_e2[k] <= BW'($signed(s_tdata[(6+k)*COORD_WIDTH +: COORD_WIDTH]));
            end
        end
    end

    // ---------------------------------------------------------------
    // Cross and dot products
    // ---------------------------------------------------------------
    logic  w_cr_valid;
    t_cvec w_c1, w_c2;
    t_bvec w_cr_e1, w_cr_e2, w_cr_bv;

    rti_cross_unit u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r1_valid),
        .i_dir   (n_dir),
        .i_e1    (r1_e1),
        .i_e2    (r1_e2),
        .i_bv    (r1_bv),
        .o_valid (w_cr_valid),
        .o_c1    (w_c1),
        .o_c2    (w_c2),
        .o_e1    (w_cr_e1),
        .o_e2    (w_cr_e2),
        .o_bv    (w_cr_bv)
    );

    logic                 w_dt_valid;
    logic signed [DW-1:0] w_det, w_nu, w_nv, w_nt;

    rti_dot_unit u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (w_cr_valid),
        .i_dir   (n_dir),
        .i_e1    (w_cr_e1),
        .i_e2    (w_cr_e2),
        .i_bv    (w_cr_bv),
        .i_c1    (w_c1),
        .i_c2    (w_c2),
        .o_valid (w_dt_valid),
        .o_det   (w_det),
        .o_nu    (w_nu),
        .o_nv    (w_nv),
        .o_nt    (w_nt)
    );

    // ---------------------------------------------------------------
    // Test stage: rejections, sign and saturation of t, divider setup
    // ---------------------------------------------------------------
    logic signed [DW-1:0] n_min;
    logic signed [DW:0]   n_uv;
    logic        [DW-1:0] n_mag;
    t_meta                n_meta;

    always_comb begin
        n_min = $signed(DW'(r_min_det));
        n_uv  = (DW+1)'(w_nu) + (DW+1)'(w_nv);
        n_mag = w_nt[DW-1] ? $unsigned(-w_nt) : $unsigned(w_nt);
        if (w_det <= 0 || (w_det >>> FRAC_BITS) < n_min) begin
            n_meta.reason = RSN_DET;
        end else if (w_nu < 0 || w_nu > w_det) begin
            n_meta.reason = RSN_U;
        end else if (w_nv < 0 || n_uv > (DW+1)'(w_det)) begin
            n_meta.reason = RSN_V;
        end else begin
            n_meta.reason = RSN_HIT;
        end
        n_meta.neg = w_nt[DW-1];
        n_meta.sat = (n_mag >> T_SAT) >= $unsigned(w_det);
    end

    logic             r6_valid;
    t_meta            r6_meta;
    logic [DW-1:0]    r6_d, r6_rt, r6_ru, r6_rv;
    logic [T_SAT-1:0] r6_tb;
    logic             r6_ub, r6_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (n_en) begin
            r6_valid <= w_dt_valid;
        end
        if (n_en) begin
            r6_meta <= n_meta;
            r6_d    <= $unsigned(w_det);
            r6_rt   <= n_mag >> T_SAT;
            r6_tb   <= n_mag[T_SAT-1:0];
            r6_ru   <= $unsigned(w_nu) >> 1;
            r6_ub   <= w_nu[0];
            r6_rv   <= $unsigned(w_nv) >> 1;
            r6_vb   <= w_nv[0];
        end
    end

    // ---------------------------------------------------------------
    // Divider
    // ---------------------------------------------------------------
    logic          w_dv_valid;
    t_meta         w_dv_meta;
    logic [QT-1:0] w_qt;
    logic [QU-1:0] w_qu, w_qv;

    rti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (r6_valid),
        .i_meta  (r6_meta),
        .i_d     (r6_d),
        .i_rt    (r6_rt),
        .i_tbits (r6_tb),
        .i_ru    (r6_ru),
        .i_ubit  (r6_ub),
        .i_rv    (r6_rv),
        .i_vbit  (r6_vb),
        .o_valid (w_dv_valid),
        .o_meta  (w_dv_meta),
        .o_qt    (w_qt),
        .o_qu    (w_qu),
        .o_qv    (w_qv)
    );

    // ---------------------------------------------------------------
    // Output register: sign of t, saturation, zeroing on a miss
    // ---------------------------------------------------------------
    logic                r_hit;
    t_reason             r_reason;
    logic [DIST_W-1:0]   r_dist;
    logic [BARY_W-1:0]   r_u, r_v;
    logic [DIST_W-1:0]   n_dist;
    logic                n_hit;

    always_comb begin
        n_hit = (w_dv_meta.reason == RSN_HIT);
        if (w_dv_meta.sat) begin
            n_dist = w_dv_meta.neg ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
        end else if (w_dv_meta.neg) begin
            n_dist = DIST_W'(0) - DIST_W'(w_qt);
        end else begin
            n_dist = DIST_W'(w_qt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_en) begin
            r_out_valid <= w_dv_valid;
        end
        if (n_en) begin
            r_hit    <= n_hit;
            r_reason <= w_dv_meta.reason;
            r_dist   <= n_hit ? n_dist : '0;
            r_u      <= n_hit ? BARY_W'(w_qu) : '0;
            r_v      <= n_hit ? BARY_W'(w_qv) : '0;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_TDATA_W'({r_v, r_u, r_dist});
    assign m_tuser  = {r_reason, r_hit};

`ifndef SYNTHESIS
    // A miss carries no distance or coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_hit |-> (r_dist == '0 && r_u == '0 && r_v == '0))
        else $error("miss result carries nonzero t/u/v");

    // Barycentrics of a hit stay inside the triangle
    a_bary_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_hit |->
            (({1'b0, r_u} + {1'b0, r_v}) <= (BARY_W+1)'(1 << OUT_FRAC)))
        else $error("u + v exceeds one on a hit");

    // A held result freezes the pipe, so no input is taken
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_tready |-> !s_tready)
        else $error("input accepted while the result is held");

    // Hit flag and reason agree
    a_hit_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_hit == (r_reason == RSN_HIT)))
        else $error("hit flag and miss reason disagree");
`endif

endmodule
